@@ design/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/lsl_pkg.sv @@
// Package with the widths, scale constants and segment tables of the lux calculator.
package lsl_pkg;

   localparam int COUNT_W   = 16;
   localparam int SCALE_W   = 19;
   localparam int SCALE_SH  = 10;
   localparam int CH_W      = 25;
   localparam int COEF_W    = 10;
   localparam int SEG_W     = 3;
   localparam int NUM_SEG   = 7;
   localparam int LUX_W     = 21;
   localparam int LUX_SH    = 14;
   localparam int PROD_W    = CH_W + COEF_W;
   localparam int CMP_W     = CH_W + COEF_W + 1;

   localparam logic [SCALE_W-1:0] SCALE_T0   = 19'h07517;
   localparam logic [SCALE_W-1:0] SCALE_T1   = 19'h00fe7;
   localparam logic [SCALE_W-1:0] SCALE_NONE = 19'h00400;

   localparam logic [1:0] MODE_13MS  = 2'd0;
   localparam logic [1:0] MODE_101MS = 2'd1;

   localparam logic [1:0] CSR_INTEG   = 2'd0;
   localparam logic [1:0] CSR_GAIN    = 2'd1;
   localparam logic [1:0] CSR_PACKAGE = 2'd2;

   localparam logic [SEG_W-1:0] SEG_NONE = 3'd7;

   typedef struct packed {
      logic [COEF_W-1:0] k;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] m;
   } seg_type;

   function automatic seg_type seg_coef(input logic pkg_cs, input logic [SEG_W-1:0] idx);
      seg_type s;
      case ({pkg_cs, idx})
         4'h0: s = '{k: 10'h040, b: 10'h1f2, m: 10'h1be};
         4'h1: s = '{k: 10'h080, b: 10'h214, m: 10'h2d1};
         4'h2: s = '{k: 10'h0c0, b: 10'h23f, m: 10'h37b};
         4'h3: s = '{k: 10'h100, b: 10'h270, m: 10'h3fe};
         4'h4: s = '{k: 10'h138, b: 10'h16f, m: 10'h1fc};
         4'h5: s = '{k: 10'h19a, b: 10'h0d2, m: 10'h0fb};
         4'h6: s = '{k: 10'h29a, b: 10'h018, m: 10'h012};
         4'h8: s = '{k: 10'h043, b: 10'h204, m: 10'h1ad};
         4'h9: s = '{k: 10'h085, b: 10'h228, m: 10'h2c1};
         4'ha: s = '{k: 10'h0c8, b: 10'h253, m: 10'h363};
         4'hb: s = '{k: 10'h10a, b: 10'h282, m: 10'h3df};
         4'hc: s = '{k: 10'h14d, b: 10'h177, m: 10'h1dd};
         4'hd: s = '{k: 10'h19a, b: 10'h101, m: 10'h127};
         4'he: s = '{k: 10'h29a, b: 10'h037, m: 10'h02b};
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

@@ design/lsl_scale.sv @@
// First pipeline stage: scales both channel counts by the integration and gain factor.
module lsl_scale import lsl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         integration_mode,
   input  logic               gain_high,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [COUNT_W-1:0] broadband_count,
   input  logic [COUNT_W-1:0] infrared_count,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [CH_W-1:0]    ch0,
   output logic [CH_W-1:0]    ch1
);

   logic [SCALE_W-1:0]         scale_base;
   logic [SCALE_W-1:0]         scale;
   logic [COUNT_W+SCALE_W-1:0] prod0;
   logic [COUNT_W+SCALE_W-1:0] prod1;
   logic                       valid_ff;
   logic [CH_W-1:0]            ch0_ff;
   logic [CH_W-1:0]            ch1_ff;
   logic [CH_W-1:0]            ch0_in;
   logic [CH_W-1:0]            ch1_in;

   always_comb begin
      case (integration_mode)
         MODE_13MS:  scale_base = SCALE_T0;
         MODE_101MS: scale_base = SCALE_T1;
         default:    scale_base = SCALE_NONE;
      endcase
      scale = gain_high ? scale_base : (scale_base << 4);
      prod0 = (COUNT_W+SCALE_W)'(broadband_count) * (COUNT_W+SCALE_W)'(scale);
      prod1 = (COUNT_W+SCALE_W)'(infrared_count) * (COUNT_W+SCALE_W)'(scale);
      ch0_in = prod0[SCALE_SH +: CH_W];
      ch1_in = prod1[SCALE_SH +: CH_W];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ch0_ff <= ch0_in;
         ch1_ff <= ch1_in;
      end
   end

   assign out_valid = valid_ff;
   assign ch0       = ch0_ff;
   assign ch1       = ch1_ff;

endmodule

@@ design/lsl_seg.sv @@
// Second pipeline stage: finds the ratio segment by cross-multiplied compares and fetches its coefficients.
module lsl_seg import lsl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              package_cs,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CH_W-1:0]   ch0,
   input  logic [CH_W-1:0]   ch1,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CH_W-1:0]   ch0_out,
   output logic [CH_W-1:0]   ch1_out,
   output logic [COEF_W-1:0] coef_b,
   output logic [COEF_W-1:0] coef_m
);

   logic [CMP_W-1:0]  lhs;
   logic [CMP_W-1:0]  rhs;
   seg_type           coef;
   seg_type           sel;
   logic [SEG_W-1:0]  seg_idx;
   logic              valid_ff;
   logic [CH_W-1:0]   ch0_ff;
   logic [CH_W-1:0]   ch1_ff;
   logic [COEF_W-1:0] b_ff;
   logic [COEF_W-1:0] m_ff;

   // The rounded ratio is at most k exactly when ch1 * 1024 < (2k + 1) * ch0.
   always_comb begin
      lhs     = CMP_W'({ch1, 10'b0});
      seg_idx = SEG_NONE;
      coef    = '0;
      rhs     = '0;
      for (int i = NUM_SEG - 1; i >= 0; i--) begin
         coef = seg_coef(package_cs, SEG_W'(i));
         rhs  = CMP_W'({coef.k, 1'b1}) * CMP_W'(ch0);
         if (lhs < rhs) begin
            seg_idx = SEG_W'(i);
         end
      end
      if (ch0 == '0) begin
         seg_idx = '0;
      end
      sel = seg_coef(package_cs, seg_idx);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ch0_ff <= ch0;
         ch1_ff <= ch1;
         b_ff   <= sel.b;
         m_ff   <= sel.m;
      end
   end

   assign out_valid = valid_ff;
   assign ch0_out   = ch0_ff;
   assign ch1_out   = ch1_ff;
   assign coef_b    = b_ff;
   assign coef_m    = m_ff;

endmodule

@@ design/lsl_lux.sv @@
// Third and fourth pipeline stages: channel products, then clamped difference, rounding and shift.
module lsl_lux import lsl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CH_W-1:0]   ch0,
   input  logic [CH_W-1:0]   ch1,
   input  logic [COEF_W-1:0] coef_b,
   input  logic [COEF_W-1:0] coef_m,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [LUX_W-1:0]  lux
);

   logic                valid3_ff;
   logic                ready3;
   logic [PROD_W-1:0]   p0_ff;
   logic [PROD_W-1:0]   p1_ff;
   logic                valid4_ff;
   logic                ready4;
   logic [LUX_W-1:0]    lux_ff;
   logic [PROD_W-1:0]   diff;
   logic [PROD_W:0]     rounded;
   logic [LUX_W-1:0]    lux_in;

   assign ready4   = !valid4_ff || out_ready;
   assign ready3   = !valid3_ff || ready4;
   assign in_ready = ready3;

   always_comb begin
      diff    = (p0_ff > p1_ff) ? (p0_ff - p1_ff) : '0;
      rounded = (PROD_W+1)'(diff) + (PROD_W+1)'(1 << (LUX_SH - 1));
      lux_in  = rounded[LUX_SH +: LUX_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (ready3) begin
            valid3_ff <= in_valid;
         end
         if (ready4) begin
            valid4_ff <= valid3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready3) begin
         p0_ff <= PROD_W'(ch0) * PROD_W'(coef_b);
         p1_ff <= PROD_W'(ch1) * PROD_W'(coef_m);
      end
      if (valid3_ff && ready4) begin
         lux_ff <= lux_in;
      end
   end

   assign out_valid = valid4_ff;
   assign lux       = lux_ff;

endmodule

@@ design/light_sensor_lux_calc.sv @@
// A request accepted on req_tready passes through the registered stages below in order
// before its result shows on rsp_tvalid. Throughput: one transaction per cycle
// while rsp_tready is high; tready ripples back through four stages.
// Stages: channel scaling, segment search, coefficient products, clamp and rounding.
// Reset is synchronous and active high; it empties the pipeline and sets the
// registers to integration_mode 2, gain_high 0 and package_cs 0.
module light_sensor_lux_calc import lsl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // broadband_count[15:0], infrared_count[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // lux[20:0], zero[23:21]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_wdata
);

   logic [1:0]        integration_mode_ff;
   logic              gain_high_ff;
   logic              package_cs_ff;
   logic              s1_valid;
   logic              s1_ready;
   logic [CH_W-1:0]   s1_ch0;
   logic [CH_W-1:0]   s1_ch1;
   logic              s2_valid;
   logic              s2_ready;
   logic [CH_W-1:0]   s2_ch0;
   logic [CH_W-1:0]   s2_ch1;
   logic [COEF_W-1:0] s2_b;
   logic [COEF_W-1:0] s2_m;
   logic [LUX_W-1:0]  lux;

   always_ff @(posedge clock) begin
      if (reset) begin
         integration_mode_ff <= 2'd2;
         gain_high_ff        <= 1'b0;
         package_cs_ff       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INTEG:   integration_mode_ff <= csr_wdata;
            CSR_GAIN:    gain_high_ff        <= csr_wdata[0];
            CSR_PACKAGE: package_cs_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   lsl_scale u_scale (
      .clock            (clock),
      .reset            (reset),
      .integration_mode (integration_mode_ff),
      .gain_high        (gain_high_ff),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .broadband_count  (req_tdata[15:0]),
      .infrared_count   (req_tdata[31:16]),
      .out_valid        (s1_valid),
      .out_ready        (s1_ready),
      .ch0              (s1_ch0),
      .ch1              (s1_ch1)
   );

   lsl_seg u_seg (
      .clock      (clock),
      .reset      (reset),
      .package_cs (package_cs_ff),
      .in_valid   (s1_valid),
      .in_ready   (s1_ready),
      .ch0        (s1_ch0),
      .ch1        (s1_ch1),
      .out_valid  (s2_valid),
      .out_ready  (s2_ready),
      .ch0_out    (s2_ch0),
      .ch1_out    (s2_ch1),
      .coef_b     (s2_b),
      .coef_m     (s2_m)
   );

   lsl_lux u_lux (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .ch0       (s2_ch0),
      .ch1       (s2_ch1),
      .coef_b    (s2_b),
      .coef_m    (s2_m),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .lux       (lux)
   );

   assign rsp_tdata = {3'b000, lux};

endmodule

@@ design/lsl_checker.sv @@
// Port-level checker for the lux calculator and its bind to the top level.
`include "assert_macros.svh"

module lsl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic rsp_stall;

   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid, "rsp_tvalid dropped")
   `ASSERT_CLK_RST(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_tdata), "rsp_tdata moved")
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_tvalid, "result shown right after reset")
   `ASSERT_CLK_RST(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[23:21] == 3'b000, "pad set")
   `ASSERT_CLK_RST(a_empty_ready, clock, reset, !rsp_tvalid |-> req_tready, "req_tready low")

endmodule

bind light_sensor_lux_calc lsl_checker u_lsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ verif/tb_light_sensor_lux_calc.sv @@
// Self-checking testbench for the lux calculator: a predictor over random and directed streams.
module tb_light_sensor_lux_calc;
   timeunit 1ns;
   timeprecision 1ps;
   import lsl_pkg::*;

   localparam int PIPE_DEPTH = 4;
   localparam logic [1:0] MODE_402MS  = 2'd2;
   localparam logic [1:0] MODE_MANUAL = 2'd3;
   localparam logic [1:0] CSR_SPARE   = 2'd3;

   localparam longint unsigned SCALE_13MS  = 64'h7517;
   localparam longint unsigned SCALE_101MS = 64'h0fe7;
   localparam longint unsigned SCALE_UNITY = 64'h0400;

   // Segment tables, indexed by package then segment.
   localparam logic [0:1][0:6][9:0] SEG_BREAK = {
      10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a,
      10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a};
   localparam logic [0:1][0:6][9:0] SEG_OFFSET = {
      10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018,
      10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037};
   localparam logic [0:1][0:6][9:0] SEG_SLOPE = {
      10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012,
      10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // broadband_count[15:0], infrared_count[31:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // lux[20:0], zero[23:21]
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [1:0]  csr_wdata;

   logic [1:0] cfg_mode;
   bit         cfg_gain;
   bit         cfg_pkg;

   logic [LUX_W-1:0] lux_pending[$];
   int unsigned idle_pct = 0;
   int unsigned stall_left = 0;
   int unsigned fail_count = 0;
   int unsigned requests_seen = 0;
   int unsigned results_seen = 0;
   int unsigned settings_seen = 0;

   light_sensor_lux_calc uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [LUX_W-1:0] lux_estimate(input logic [15:0] broadband,
                                                    input logic [15:0] infrared);
      longint unsigned scale, ch0, ch1, ratio, offset, slope, p0, p1, diff;
      bit found;
      case (cfg_mode)
         MODE_13MS:  scale = SCALE_13MS;
         MODE_101MS: scale = SCALE_101MS;
         default:    scale = SCALE_UNITY;
      endcase
      if (!cfg_gain) scale = scale << 4;
      ch0 = (broadband * scale) >> 10;
      ch1 = (infrared * scale) >> 10;
      ratio = 0;
      if (ch0 != 0) ratio = (ch1 << 10) / ch0;
      ratio = (ratio + 1) >> 1;
      offset = 0;
      slope = 0;
      found = 1'b0;
      for (int i = 0; i < 7; i++) begin
         if (!found && ratio <= SEG_BREAK[cfg_pkg][i]) begin
            offset = SEG_OFFSET[cfg_pkg][i];
            slope = SEG_SLOPE[cfg_pkg][i];
            found = 1'b1;
         end
      end
      p0 = ch0 * offset;
      p1 = ch1 * slope;
      diff = (p0 > p1) ? p0 - p1 : 0;
      diff = diff + (64'd1 << 13);
      return LUX_W'(diff >> 14);
   endfunction

   always @(posedge clock) begin : lux_monitor
      logic [LUX_W-1:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            lux_pending.push_back(lux_estimate(req_tdata[15:0], req_tdata[31:16]));
            requests_seen++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (lux_pending.size() == 0) begin
               $error("lux: result transaction with nothing expected, actual %0d",
                      rsp_tdata[20:0]);
               fail_count++;
            end else begin
               want = lux_pending.pop_front();
               if (rsp_tdata[20:0] !== want) begin
                  $error("lux: expected %0d, actual %0d", want, rsp_tdata[20:0]);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_counts(input logic [15:0] broadband, input logic [15:0] infrared);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {infrared, broadband};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic draw_counts(output logic [15:0] broadband, output logic [15:0] infrared);
      int unsigned ratio_q10, wide;
      case ($urandom_range(0, 9))
         0: begin
            broadband = 16'($urandom_range(0, 65535));
            infrared = 16'($urandom_range(0, 65535));
         end
         1: begin
            broadband = ($urandom_range(0, 1) ? 16'hffff : 16'h0000) ^ 16'($urandom_range(0, 1));
            infrared = ($urandom_range(0, 1) ? 16'hffff : 16'h0000) ^ 16'($urandom_range(0, 1));
         end
         2: begin
            broadband = 16'($urandom_range(0, 63));
            infrared = 16'($urandom_range(0, 63));
         end
         default: begin
            broadband = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            ratio_q10 = $urandom_range(0, 1500);
            wide = (broadband * ratio_q10) >> 10;
            infrared = (wide > 65535) ? 16'hffff : 16'(wide);
         end
      endcase
   endtask

   task automatic settle_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lux_pending.size() != 0 || stall_left != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_INTEG:   cfg_mode = value;
         CSR_GAIN:    cfg_gain = value[0];
         CSR_PACKAGE: cfg_pkg = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [1:0] mode, input bit gain, input bit pkg);
      settle_pipeline();
      write_reg(CSR_INTEG, mode);
      write_reg(CSR_GAIN, {1'($urandom_range(0, 1)), gain});
      write_reg(CSR_PACKAGE, {1'($urandom_range(0, 1)), pkg});
      csr_we <= 1'b0;
      settings_seen++;
   endtask

   task automatic test_reset_defaults();
      send_counts(16'h0000, 16'h0000);
      send_counts(16'hffff, 16'h0000);
      send_counts(16'hffff, 16'hffff);
      send_counts(16'h0000, 16'hffff);
      send_counts(16'h0001, 16'h0000);
      send_counts(16'h0000, 16'h0001);
   endtask

   // With equal channel scaling, a broadband count of 512 makes the rounded ratio equal the infrared count.
   task automatic test_segment_breaks();
      for (int i = 0; i < 7; i++) begin
         send_counts(16'd512, 16'(SEG_BREAK[0][i]));
         send_counts(16'd512, 16'(SEG_BREAK[0][i]) + 16'd1);
      end
   endtask

   // Near the last break of the CS table the slope term exceeds the offset term.
   task automatic test_cs_clamp();
      apply_setting(MODE_402MS, 1'b0, 1'b1);
      send_counts(16'd512, 16'd640);
      send_counts(16'd512, 16'd660);
      send_counts(16'd512, 16'd666);
      send_counts(16'd512, 16'd667);
   endtask

   task automatic test_ignored_writes();
      logic [15:0] broadband, infrared;
      settle_pipeline();
      write_reg(CSR_SPARE, 2'($urandom_range(0, 3)));
      write_reg(CSR_GAIN, 2'b11);
      write_reg(CSR_PACKAGE, 2'b10);
      write_reg(CSR_INTEG, MODE_101MS);
      csr_we <= 1'b0;
      settings_seen++;
      repeat (6) begin
         draw_counts(broadband, infrared);
         send_counts(broadband, infrared);
      end
   endtask

   task automatic test_all_settings();
      logic [15:0] broadband, infrared;
      for (int s = 0; s < 16; s++) begin
         apply_setting(2'(s), s[2], s[3]);
         for (int n = 0; n < 60; n++) begin
            if (n % 20 == 0) begin
               case ($urandom_range(0, 3))
                  0: idle_pct = 0;
                  1: idle_pct = 3;
                  2: idle_pct = 15;
                  default: idle_pct = 40;
               endcase
            end
            draw_counts(broadband, infrared);
            send_counts(broadband, infrared);
         end
      end
   endtask

   task automatic test_back_to_back();
      logic [15:0] broadband, infrared;
      idle_pct = 0;
      apply_setting(MODE_13MS, 1'b0, 1'($urandom_range(0, 1)));
      send_counts(16'hffff, 16'h0000);
      send_counts(16'hffff, 16'hffff);
      repeat (70) begin
         draw_counts(broadband, infrared);
         send_counts(broadband, infrared);
      end
      apply_setting(MODE_MANUAL, 1'b1, 1'($urandom_range(0, 1)));
      repeat (70) begin
         draw_counts(broadband, infrared);
         send_counts(broadband, infrared);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_INTEG;
      csr_wdata = '0;
      cfg_mode = MODE_402MS;
      cfg_gain = 1'b0;
      cfg_pkg = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_segment_breaks();
      test_cs_clamp();
      test_ignored_writes();
      test_all_settings();
      test_back_to_back();
      settle_pipeline();
      $display("Run covered %0d request and %0d result transactions over %0d register settings,",
               requests_seen, results_seen, settings_seen);
      $display("spanning every integration mode, gain and package with random stalls on both sides.");
      if (fail_count == 0) begin
         $display("tb_light_sensor_lux_calc passed");
      end else begin
         $display("tb_light_sensor_lux_calc failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_light_sensor_lux_calc failed");
      $finish;
   end

endmodule
